### src/asp_pkg.sv
// Shared types and constants for the array subscript text parser.
`timescale 1ns / 1ps
`default_nettype none

package asp_pkg;

    localparam int MAG_W = 31;
    localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        PH_SPACE  = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2,
        PH_REJECT = 2'd3
    } phase_t;

    typedef struct packed {
        phase_t           phase;
        logic             is_negative;
        logic [MAG_W-1:0] magnitude;
        logic             too_big;
        logic             text_ended;
    } parse_state_t;

    localparam parse_state_t PARSE_INIT = '{
        phase:       PH_SPACE,
        is_negative: 1'b0,
        magnitude:   '0,
        too_big:     1'b0,
        text_ended:  1'b0
    };

endpackage

`default_nettype wire

### src/array_subscript_text_parser_top.sv
// Top level of the array subscript text parser.
// Usage:
//   Input channel (in_valid / in_stall) carries one character of subscript
//   text per item; char_present qualifies text_char, and the item with last
//   set also carries array_size. A zero byte ends the text early.
//   Output channel (out_valid / out_stall) carries one item per text:
//   found, and index (zero when found is clear).
//   Result path: the final item is captured in the input register, and the
//   result is loaded into the output register when that item moves on,
//   which a full, stalled output register can delay.
//   Throughput: one character per cycle unless an item with last is held,
//   set by the combinational multiply-by-ten and accumulate on the parse state.
//   Stall: a held result keeps its values; characters without last keep
//   flowing, and only an item with last waits in the input register while
//   the output register is full and stalled, raising in_stall.
//   Reset: asynchronous, clears both valid bits and returns the parse
//   state to skipping leading whitespace. The state also returns there
//   after every text.
`timescale 1ns / 1ps
`default_nettype none

module array_subscript_text_parser_top #(
    parameter int SIZE_BITS = 28
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                text_char,
    input  logic                      char_present,
    input  logic                      last,
    input  logic [SIZE_BITS-1:0]      array_size,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      found,
    output logic [asp_pkg::MAG_W-1:0] index
);
    import asp_pkg::*;

    logic                 s1_valid_reg;
    logic [7:0]           s1_char_reg;
    logic                 s1_present_reg;
    logic                 s1_last_reg;
    logic [SIZE_BITS-1:0] s1_size_reg;

    parse_state_t         state_reg;
    parse_state_t         state_next;

    logic                 out_valid_reg;
    logic                 found_reg;
    logic [MAG_W-1:0]     index_reg;

    logic                 res_found;
    logic [MAG_W-1:0]     res_index;
    logic                 out_free;
    logic                 s1_moves;
    logic                 s1_load;
    logic                 out_load;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_moves = s1_valid_reg && (!s1_last_reg || out_free);
    assign s1_load  = !s1_valid_reg || s1_moves;
    assign out_load = s1_moves && s1_last_reg;
    assign in_stall = !s1_load;

    asp_char_step u_step (
        .cur          (state_reg),
        .text_char    (s1_char_reg),
        .char_present (s1_present_reg),
        .nxt          (state_next)
    );

    asp_resolve u_resolve (
        .st    (state_next),
        .size  (MAG_W'(s1_size_reg)),
        .found (res_found),
        .index (res_index)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= PARSE_INIT;
        end
        else
        begin
            if (s1_load)
                s1_valid_reg <= in_valid;
            if (s1_moves)
                state_reg <= s1_last_reg ? PARSE_INIT : state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_char_reg    <= text_char;
            s1_present_reg <= char_present;
            s1_last_reg    <= last;
            s1_size_reg    <= array_size;
        end
        if (out_load)
        begin
            found_reg <= res_found;
            index_reg <= res_index;
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign index     = index_reg;

endmodule

`default_nettype wire

### src/asp_char_step.sv
// Next parser state for one character of subscript text.
`timescale 1ns / 1ps
`default_nettype none

module asp_char_step (
    input  asp_pkg::parse_state_t cur,
    input  logic [7:0]            text_char,
    input  logic                  char_present,
    output asp_pkg::parse_state_t nxt
);
    import asp_pkg::*;

    logic            is_space;
    logic            is_digit;
    logic            handled;
    logic [MAG_W+3:0] scaled;

    assign is_space = (text_char == CH_SPACE) ||
                      ((text_char >= CH_TAB) && (text_char <= CH_CR));
    assign is_digit = (text_char >= CH_ZERO) && (text_char <= CH_NINE);

    // magnitude * 10 + digit
    assign scaled = ((MAG_W+4)'(cur.magnitude) << 3) + ((MAG_W+4)'(cur.magnitude) << 1)
                  + (MAG_W+4)'(text_char[3:0]);

    always_comb
    begin
        nxt     = cur;
        handled = 1'b0;
        if (char_present && !cur.text_ended)
        begin
            if (text_char == CH_NUL)
            begin
                nxt.text_ended = 1'b1;
            end
            else
            begin
                if (cur.phase == PH_SPACE)
                begin
                    if (is_space)
                    begin
                        handled = 1'b1;
                    end
                    else if (text_char == CH_MINUS)
                    begin
                        nxt.is_negative = 1'b1;
                        nxt.phase       = PH_SIGN;
                        handled         = 1'b1;
                    end
                    else if (text_char == CH_PLUS)
                    begin
                        nxt.phase = PH_SIGN;
                        handled   = 1'b1;
                    end
                end
                if (!handled && (cur.phase != PH_REJECT))
                begin
                    if (!is_digit)
                    begin
                        nxt.phase = PH_REJECT;
                    end
                    else
                    begin
                        nxt.phase = PH_DIGITS;
                        if (!cur.too_big)
                        begin
                            if (scaled > (MAG_W+4)'(MAG_MAX))
                                nxt.too_big = 1'b1;
                            else
                                nxt.magnitude = scaled[MAG_W-1:0];
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

### src/asp_resolve.sv
// Turns the final parser state and array size into found flag and index.
`timescale 1ns / 1ps
`default_nettype none

module asp_resolve (
    input  asp_pkg::parse_state_t     st,
    input  logic [asp_pkg::MAG_W-1:0] size,
    output logic                      found,
    output logic [asp_pkg::MAG_W-1:0] index
);
    import asp_pkg::*;

    logic             good;
    logic             from_end;
    logic [MAG_W:0]   diff;

    assign good     = (st.phase == PH_DIGITS) && !st.too_big;
    assign from_end = st.is_negative && (st.magnitude != '0);
    // negative: size - magnitude, valid while no borrow
    assign diff     = {1'b0, size} - {1'b0, st.magnitude};

    always_comb
    begin
        found = 1'b0;
        index = '0;
        if (good)
        begin
            if (from_end)
            begin
                if (!diff[MAG_W])
                begin
                    found = 1'b1;
                    index = diff[MAG_W-1:0];
                end
            end
            else if (st.magnitude < size)
            begin
                found = 1'b1;
                index = st.magnitude;
            end
        end
    end

endmodule

`default_nettype wire

### src/asp_checker.sv
// Port-level assertions for the array subscript text parser, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module asp_checker #(
    parameter int SIZE_BITS = 28
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [7:0]                text_char,
    input logic                      char_present,
    input logic                      last,
    input logic [SIZE_BITS-1:0]      array_size,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      found,
    input logic [asp_pkg::MAG_W-1:0] index
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(found) && $stable(index))
        else $error("held result changed");

    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> index == '0)
        else $error("null result with nonzero index");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output can drain");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && !in_stall && last, 2))
        else $error("result without a final item two edges earlier");

endmodule

bind array_subscript_text_parser_top asp_checker #(.SIZE_BITS(SIZE_BITS)) u_asp_checker (.*);

`default_nettype wire

### verif/tb_top.sv
// Self-checking testbench for the array subscript text parser: directed and random texts.
`timescale 1ns / 1ps

module tb_top;
    import asp_pkg::*;

    localparam int SZ_W = 28;
    localparam logic [SZ_W-1:0] SIZE_MAX = {SZ_W{1'b1}};
    localparam int STUCK_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic             found;
        logic [MAG_W-1:0] index;
    } subscript_result_t;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_stall;
    logic [7:0]       text_char;
    logic             char_present;
    logic             last;
    logic [SZ_W-1:0]  array_size;
    logic             out_valid;
    logic             out_stall;
    logic             found;
    logic [MAG_W-1:0] index;

    subscript_result_t resolved_q[$];
    logic [7:0]        text_q[$];
    parse_state_t      parse_st;
    int                err_count = 0;
    int                text_items = 0;
    int                idle_pct;
    int                rx_idle_pct;
    bit                hold_req;

    array_subscript_text_parser_top #(.SIZE_BITS(SZ_W)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .text_char    (text_char),
        .char_present (char_present),
        .last         (last),
        .array_size   (array_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .found        (found),
        .index        (index)
    );

    always #4 clk = ~clk;

    function automatic bit is_ws(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic void scan_char(logic [7:0] c);
        logic [63:0] acc;
        if (c == CH_NUL)
        begin
            parse_st.text_ended = 1'b1;
            return;
        end
        if (parse_st.phase == PH_SPACE)
        begin
            if (is_ws(c))
                return;
            if (c == CH_MINUS)
            begin
                parse_st.is_negative = 1'b1;
                parse_st.phase = PH_SIGN;
                return;
            end
            if (c == CH_PLUS)
            begin
                parse_st.phase = PH_SIGN;
                return;
            end
        end
        if (parse_st.phase == PH_REJECT)
            return;
        if (c < CH_ZERO || c > CH_NINE)
        begin
            parse_st.phase = PH_REJECT;
            return;
        end
        parse_st.phase = PH_DIGITS;
        if (!parse_st.too_big)
        begin
            acc = 64'(parse_st.magnitude) * 64'd10 + 64'(c - CH_ZERO);
            if (acc > 64'(MAG_MAX))
                parse_st.too_big = 1'b1;
            else
                parse_st.magnitude = acc[MAG_W-1:0];
        end
    endfunction

    function automatic subscript_result_t resolve_subscript(logic [SZ_W-1:0] sz);
        subscript_result_t r;
        logic [63:0]       idx;
        bit                ok;
        r = '0;
        idx = '0;
        ok = 1'b0;
        if (parse_st.phase == PH_DIGITS && !parse_st.too_big)
        begin
            if (!parse_st.is_negative || parse_st.magnitude == '0)
            begin
                idx = 64'(parse_st.magnitude);
                ok = idx < 64'(sz);
            end
            else if (64'(parse_st.magnitude) <= 64'(sz))
            begin
                idx = 64'(sz) - 64'(parse_st.magnitude);
                ok = idx < 64'(sz);
            end
        end
        if (ok)
        begin
            r.found = 1'b1;
            r.index = idx[MAG_W-1:0];
        end
        parse_st = PARSE_INIT;
        return r;
    endfunction

    task automatic send_item(logic [7:0] c, bit pres, bit lst, logic [SZ_W-1:0] sz);
        int gap;
        @(negedge clk);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            gap = $urandom_range(1, 15);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_char = c;
        char_present = pres;
        last = lst;
        array_size = sz;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        if (pres && !parse_st.text_ended)
            scan_char(c);
        if (lst)
            resolved_q.push_back(resolve_subscript(sz));
        if (pres || lst)
            text_items++;
    endtask

    task automatic put_str(string s);
        int k;
        for (k = 0; k < s.len(); k++)
            text_q.push_back(s[k]);
    endtask

    task automatic send_text(logic [SZ_W-1:0] sz, bit last_alone, bit noisy);
        int i;
        bit lst;
        for (i = 0; i < text_q.size(); i++)
        begin
            if (noisy && $urandom_range(0, 19) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, SZ_W'($urandom));
            lst = !last_alone && i == text_q.size() - 1;
            send_item(text_q[i], 1'b1, lst, lst ? sz : SZ_W'($urandom));
        end
        if (last_alone || text_q.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, sz);
        text_q.delete();
    endtask

    task automatic send_str(string s, logic [SZ_W-1:0] sz);
        put_str(s);
        send_text(sz, 1'b0, 1'b0);
    endtask

    task automatic wait_results_done();
        @(negedge clk);
        in_valid = 1'b0;
        while (resolved_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic build_random_text(output logic [SZ_W-1:0] sz);
        longint unsigned val;
        longint          near;
        int              form;
        int              k;
        int              sel;
        form = $urandom_range(0, 99);
        repeat ($urandom_range(0, 2))
        begin
            k = $urandom_range(0, 5);
            text_q.push_back(k == 5 ? CH_SPACE : 8'(CH_TAB + k));
        end
        case ($urandom_range(0, 3))
            0, 1: text_q.push_back(CH_MINUS);
            2: text_q.push_back(CH_PLUS);
            default: ;
        endcase
        sel = $urandom_range(0, 9);
        if (sel < 4)
            val = 64'($urandom_range(0, 40));
        else if (sel < 8)
            val = 64'($urandom_range(0, SIZE_MAX));
        else if (sel == 8)
            val = 64'd2147483630 + $urandom_range(0, 40);
        else
            val = {$urandom, $urandom} % 64'd100000000000;
        if (form < 95)
        begin
            if ($urandom_range(0, 99) < 15)
                repeat ($urandom_range(1, 3)) text_q.push_back(CH_ZERO);
            put_str($sformatf("%0d", val));
        end
        if (form >= 70 && form < 80)
        begin
            text_q.push_back(CH_NUL);
            repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
        end
        else if (form >= 80 && form < 88)
            text_q.push_back(8'($urandom_range(0, 255)));
        else if (form >= 88 && form < 92)
            text_q.push_back(CH_SPACE);
        else if (form >= 92 && form < 95)
            text_q.push_front(8'($urandom_range(0, 255)));
        sel = $urandom_range(0, 19);
        if (sel < 5)
            sz = SZ_W'($urandom_range(0, 40));
        else if (sel < 12 && val <= SIZE_MAX)
        begin
            near = longint'(val) + longint'($urandom_range(0, 4)) - 2;
            if (near < 0)
                near = 0;
            if (near > longint'(SIZE_MAX))
                near = longint'(SIZE_MAX);
            sz = near[SZ_W-1:0];
        end
        else if (sel < 15)
            sz = SIZE_MAX;
        else if (sel == 15)
            sz = '0;
        else
            sz = SZ_W'($urandom);
    endtask

    task automatic test_directed_texts();
        logic [7:0] c;
        idle_pct = 0;
        rx_idle_pct = 0;
        send_text(28'd5, 1'b0, 1'b0);
        send_str("   ", 28'd5);
        send_str("+", 28'd5);
        send_str("-", 28'd5);
        send_str("0", 28'd1);
        send_str("0", 28'd0);
        send_str("-0", 28'd3);
        for (c = CH_TAB; c <= CH_CR; c++)
            text_q.push_back(c);
        send_str(" +4", 28'd5);
        send_str("12a", 28'd100);
        send_str("12 ", 28'd100);
        send_str("x12", 28'd100);
        send_str("+-3", 28'd100);
        send_str("-3", 28'd3);
        send_str("-4", 28'd3);
        send_str("5", 28'd5);
        send_str("4", 28'd5);
        send_str("2147483647", SIZE_MAX);
        send_str("268435454", SIZE_MAX);
        send_str("2147483648", SIZE_MAX);
        send_str("-2147483648", SIZE_MAX);
        send_str("-268435455", SIZE_MAX);
        put_str("7");
        text_q.push_back(CH_NUL);
        send_str("x9", 28'd10);
        text_q.push_back(CH_NUL);
        send_str("5", 28'd10);
        repeat (30) text_q.push_back(CH_ZERO);
        send_str("42", 28'd100);
        text_q.push_back(8'hFF);
        send_text(28'd10, 1'b0, 1'b0);
        put_str("8");
        send_text(28'd9, 1'b1, 1'b0);
    endtask

    task automatic test_random_texts(int n_items);
        int              goal;
        int              n_texts;
        logic [SZ_W-1:0] sz;
        goal = text_items + n_items;
        n_texts = 0;
        while (text_items < goal)
        begin
            if (n_texts % 40 == 0)
            begin
                idle_pct = (idle_pct == 0) ? 20 : 0;
                rx_idle_pct = $urandom_range(0, 1) ? 20 : 0;
            end
            build_random_text(sz);
            send_text(sz, $urandom_range(0, 9) == 0, 1'b1);
            n_texts++;
        end
    endtask

    task automatic test_output_hold();
        int i;
        idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        for (i = 0; i < 12; i++)
        begin
            put_str($sformatf("%0d", i * 7));
            send_text(28'd50, 1'b0, 1'b0);
        end
        while (hold_req)
            @(posedge clk);
    endtask

    task automatic test_steady_stream(int n_items);
        int              goal;
        logic [SZ_W-1:0] sz;
        idle_pct = 0;
        rx_idle_pct = 0;
        goal = text_items + n_items;
        while (text_items < goal)
        begin
            build_random_text(sz);
            send_text(sz, $urandom_range(0, 9) == 0, 1'b0);
        end
    endtask

    // receiver: random stall bursts plus one long hold on request
    initial
    begin
        int n;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall = 1'b0;
                hold_req = 1'b0;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                n = $urandom_range(1, 15);
                out_stall = 1'b1;
                repeat (n) @(negedge clk);
                out_stall = 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin : check_results
        subscript_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (resolved_q.size() == 0)
            begin
                err_count++;
                $error("unexpected result: found=%0b index=%0d", found, index);
            end
            else
            begin
                want = resolved_q.pop_front();
                if (found !== want.found)
                begin
                    err_count++;
                    $error("found: expected %0b, actual %0b", want.found, found);
                end
                if (index !== want.index)
                begin
                    err_count++;
                    $error("index: expected %0d, actual %0d", want.index, index);
                end
            end
        end
    end

    initial
    begin
        int stuck;
        stuck = 0;
        @(posedge rst_n);
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("** array_subscript_text_parser_top: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        text_char = '0;
        char_present = 1'b0;
        last = 1'b0;
        array_size = '0;
        idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b0;
        parse_st = PARSE_INIT;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_texts();
        wait_results_done();
        test_random_texts(900);
        wait_results_done();
        test_output_hold();
        wait_results_done();
        test_random_texts(350);
        wait_results_done();
        test_steady_stream(300);
        @(negedge clk);
        in_valid = 1'b0;
        wait_results_done();
        repeat (10) @(posedge clk);

        if (err_count == 0)
            $display("** array_subscript_text_parser_top: PASSED **");
        else
            $display("** array_subscript_text_parser_top: FAILED **");
        $finish;
    end

endmodule

### sim.f
src/asp_pkg.sv
src/asp_char_step.sv
src/asp_resolve.sv
src/array_subscript_text_parser_top.sv
src/asp_checker.sv
verif/tb_top.sv
